### src/lspf_pkg.sv
// ----------------------------------------------------------------------------
// lspf_pkg - shared types and constants for the sector proximity flags unit
// Point and result payloads, configuration set, register indexes, and the
// angle-to-sector helper.
// ----------------------------------------------------------------------------
package lspf_pkg;

  localparam int SECTOR_COUNT = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FLUCT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LIMIT = 2'd2;

  localparam logic [7:0]  THRESHOLD_RESET   = 8'd24;
  localparam logic [7:0]  MAX_FLUCT_RESET   = 8'd2;
  localparam logic [13:0] RANGE_LIMIT_RESET = 14'd3000;

  localparam logic [3:0]  NO_SECTOR = 4'd15;
  localparam logic [17:0] MIN_RESET = 18'h3FFFF;

  // quarter millimetres to inches in Q.8 is d*645/256
  localparam logic [9:0]  QMM_TO_Q8 = 10'd645;

  // flags exist only for sectors below both the sector count and eight
  localparam logic [4:0] FLAG_LIMIT = (SECTOR_COUNT < 8) ? 5'(SECTOR_COUNT) : 5'd8;

  typedef struct packed {
    logic [14:0] angle_q6;
    logic [15:0] distance_qmm;
  } pt_t;

  typedef struct packed {
    logic [3:0]  closed_sector;
    logic [17:0] sector_min_q8;
    logic [9:0]  sector_max_inches;
    logic        was_stable;
    logic [7:0]  flags;
  } res_t;

  typedef struct packed {
    logic [7:0]  threshold_inches;
    logic [7:0]  max_fluctuation;
    logic [13:0] range_limit_mm;
  } cfg_t;

  // whole degrees divided by 45: count the sector boundaries passed
  function automatic logic [3:0] sector_of(input logic [8:0] degrees);
    logic [3:0] count;
    count = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (degrees >= 9'(45 * k)) begin
        count = count + 4'd1;
      end
    end
    return count;
  endfunction

endpackage

### src/lspf_in_stage.sv
// ----------------------------------------------------------------------------
// lspf_in_stage - point input register
// Captures one point request per cycle while pt_stall is low and holds it until the tracker takes it.
// ----------------------------------------------------------------------------
module lspf_in_stage
  import lspf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pt_valid,
  output logic pt_stall,
  input  pt_t  pt,
  input  logic advance,
  output logic item_valid,
  output pt_t  item
);

  logic accept;

  // refill in the same cycle the held point moves on
  assign pt_stall = item_valid && !advance;
  assign accept   = pt_valid && !pt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= pt;
    end
  end

endmodule

### src/lspf_tracker.sv
// ----------------------------------------------------------------------------
// lspf_tracker - sector tracking and flag update
// Converts the distance, picks the sector, keeps the running min and max, and
// closes a sector into a result when the angle moves on.
// ----------------------------------------------------------------------------
module lspf_tracker
  import lspf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic item_valid,
  input  pt_t  item,
  input  logic out_free,
  output logic advance,
  output logic produce,
  output res_t result
);

  logic [3:0]  open_sector;
  logic [17:0] run_min_q8;
  logic [9:0]  run_max_whole;
  logic [17:0] last_inches_q8;
  logic [7:0]  sector_flags;

  logic [25:0] product;
  logic        in_range;
  logic [17:0] inches;
  logic [3:0]  sector;
  logic        change;
  logic        close_req;
  logic signed [18:0] diff;
  logic [17:0] neg_mag;
  logic        stable;
  logic [7:0]  flag_mask;
  logic [7:0]  flags_next;
  logic [17:0] base_min;
  logic [9:0]  base_max;
  logic [17:0] min_next;
  logic [9:0]  max_next;

  always_comb begin
    product  = {10'd0, item.distance_qmm} * {16'd0, QMM_TO_Q8};
    in_range = {2'b00, item.distance_qmm} < {2'b00, cfg.range_limit_mm, 2'b00};
    inches   = (item.distance_qmm != 16'd0) ? product[25:8] : last_inches_q8;
    sector   = sector_of(item.angle_q6[14:6]);
    change   = sector != open_sector;
    close_req = in_range && change && (open_sector != NO_SECTOR);

    // variation truncates toward zero
    diff    = $signed({1'b0, run_max_whole, 8'd0}) - $signed({1'b0, run_min_q8});
    neg_mag = 18'(-diff);
    if (!diff[18]) begin
      stable = diff[17:8] < {2'b00, cfg.max_fluctuation};
    end else begin
      stable = (neg_mag[17:8] != 10'd0) || (cfg.max_fluctuation != 8'd0);
    end

    flag_mask  = 8'd1 << open_sector[2:0];
    flags_next = sector_flags;
    if (stable && ({1'b0, open_sector} < FLAG_LIMIT)) begin
      if (run_min_q8 > {2'b00, cfg.threshold_inches, 8'd0}) begin
        flags_next = sector_flags | flag_mask;
      end else begin
        flags_next = sector_flags & ~flag_mask;
      end
    end

    // restart tracking on a new sector, then fold in the current point
    base_min = change ? MIN_RESET : run_min_q8;
    base_max = change ? 10'd0 : run_max_whole;
    min_next = (inches < base_min) ? inches : base_min;
    max_next = (inches > {base_max, 8'd0}) ? inches[17:8] : base_max;

    result.closed_sector     = open_sector;
    result.sector_min_q8     = run_min_q8;
    result.sector_max_inches = run_max_whole;
    result.was_stable        = stable;
    result.flags             = flags_next;
  end

  // a point that closes a sector waits for room in the result register
  assign produce = close_req;
  assign advance = item_valid && (!close_req || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      open_sector    <= NO_SECTOR;
      run_min_q8     <= MIN_RESET;
      run_max_whole  <= 10'd0;
      last_inches_q8 <= 18'd0;
      sector_flags   <= 8'd0;
    end else if (advance && in_range) begin
      open_sector    <= sector;
      run_min_q8     <= min_next;
      run_max_whole  <= max_next;
      last_inches_q8 <= inches;
      if (close_req) begin
        sector_flags <= flags_next;
      end
    end
  end

endmodule

### src/lspf_out_stage.sv
// ----------------------------------------------------------------------------
// lspf_out_stage - result register
// Holds a closed-sector result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lspf_out_stage
  import lspf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t result,
  output logic out_free,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (out_free) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= result;
    end
  end

endmodule

### src/lidar_sector_proximity_flags_unit.sv
// Sector proximity flags from a lidar point stream. The unit takes one point
// per clock while pt_stall is low and returns a result whenever an in-range
// point enters a new 45-degree sector while one is open, carrying the closed
// sector's min (inches, Q.8), max (whole inches), stability and the
// updated flag byte. Points sit in the point input register, results in the
// result register; the tracker's state update sets the one-point-per-cycle rate.
// A stalled result holds back only points that close another sector.
// ----------------------------------------------------------------------------
// lidar_sector_proximity_flags_unit - top level
// Configuration registers, point input register, tracker and result register.
// ----------------------------------------------------------------------------
module lidar_sector_proximity_flags_unit
  import lspf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pt_valid,
  output logic                   pt_stall,
  input  pt_t                    pt,
  output logic                   res_valid,
  input  logic                   res_stall,
  output res_t                   res
);

  cfg_t cfg;
  logic item_valid;
  pt_t  item;
  logic advance;
  logic produce;
  logic out_free;
  res_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_inches <= THRESHOLD_RESET;
      cfg.max_fluctuation  <= MAX_FLUCT_RESET;
      cfg.range_limit_mm   <= RANGE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:   cfg.threshold_inches <= cfg_data[7:0];
        CFG_MAX_FLUCT:   cfg.max_fluctuation  <= cfg_data[7:0];
        CFG_RANGE_LIMIT: cfg.range_limit_mm   <= cfg_data;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  lspf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .pt_valid   (pt_valid),
    .pt_stall   (pt_stall),
    .pt         (pt),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lspf_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .advance    (advance),
    .produce    (produce),
    .result     (result)
  );

  lspf_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (produce && advance),
    .result    (result),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
